>>> rtl/tked_pkg.sv
// Package with key codes, byte codes and the result burst type of the key escape decoder.
package tked_pkg;

  // Key codes carried in the key_code field.
  typedef enum logic [2:0] {
    KEY_NONE = 3'd0,
    KEY_QUIT = 3'd1,
    KEY_UP   = 3'd2,
    KEY_DOWN = 3'd3,
    KEY_PGUP = 3'd4,
    KEY_PGDN = 3'd5,
    KEY_HOME = 3'd6,
    KEY_END  = 3'd7
  } key_t;

  // Bytes that take part in the escape sequences and the single-byte keys.
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_CTRL_C = 8'h03;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;  // '~'

  // Bytes consumed by a single byte, a short sequence and a numbered sequence.
  localparam logic [2:0] USED_ONE   = 3'd1;
  localparam logic [2:0] USED_SHORT = 3'd3;
  localparam logic [2:0] USED_NUM   = 3'd4;

  // Results caused by one input byte: a run of none results for a failed
  // prefix, followed optionally by one final result.
  typedef struct packed {
    logic [1:0] nones;
    logic       fin_valid;
    key_t       fin_key;
    logic [2:0] fin_used;
  } burst_t;

  // Key for a byte decoded on its own.
  function automatic key_t single_key(input logic [7:0] b);
    key_t k;
    case (b)
      "q", "Q", BYTE_CTRL_C: k = KEY_QUIT;
      "k":                   k = KEY_UP;
      "j":                   k = KEY_DOWN;
      " ", "f":              k = KEY_PGDN;
      "b":                   k = KEY_PGUP;
      "g":                   k = KEY_HOME;
      "G":                   k = KEY_END;
      default:               k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/terminal_key_escape_decoder_unit.sv
// Top level of the terminal key escape decoder: input handshake, result burst register and output.
//
// The s_ channel takes one terminal byte per transaction. The m_ channel
// gives key events: each byte yields zero to four results, the last of
// which carries m_tlast. A byte that extends a pending escape prefix
// yields no result; the prefix is held for as long as it takes.
// A failed prefix gives one none result per held byte before the new byte
// is decoded.
// A result is registered and appears on m_ in the cycle after its byte
// is accepted. The output register drains one result per cycle while
// m_tready is high; the next byte is taken in the cycle its predecessor's
// last result leaves, so bytes with one or no result stream at one per
// cycle while the receiver is ready.
// Reset clears the held prefix and drops any pending results.
// While the receiver stalls, the pending result holds and s_tready stays
// low until the final result of the burst is taken.
module terminal_key_escape_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [2:0] key_code, [5:3] bytes_consumed, [7:6] zero
  output logic       m_tlast    // last_of_run
);

  logic             s_accept;
  logic             m_accept;
  logic             busy;
  logic             final_beat;
  tked_pkg::burst_t dec_burst;
  tked_pkg::burst_t burst, burst_next;
  tked_pkg::key_t   out_key;
  logic [2:0]       out_used;

  tked_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .data_byte (s_tdata),
    .burst     (dec_burst)
  );

  // Handshake: a new byte enters when the burst register is empty or its
  // final result leaves in this cycle.
  assign busy       = (burst.nones != 2'd0) || burst.fin_valid;
  assign final_beat = (burst.nones == 2'd0) || ((burst.nones == 2'd1) && !burst.fin_valid);
  assign m_accept   = m_tvalid && m_tready;
  assign s_tready   = !busy || (m_tready && final_beat);
  assign s_accept   = s_tvalid && s_tready;

  // Current result: pending nones go first, then the final result.
  always_comb begin
    if (burst.nones != 2'd0) begin
      out_key  = tked_pkg::KEY_NONE;
      out_used = tked_pkg::USED_ONE;
    end else begin
      out_key  = burst.fin_key;
      out_used = burst.fin_used;
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = final_beat;
  assign m_tdata  = {2'b00, out_used, out_key};

  // Burst register: step through results, reload on an accepted byte.
  always_comb begin
    burst_next = burst;
    if (m_accept) begin
      if (burst.nones != 2'd0) begin
        burst_next.nones = burst.nones - 2'd1;
      end else begin
        burst_next.fin_valid = 1'b0;
      end
    end
    if (s_accept) begin
      burst_next = dec_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst <= '0;
    end else begin
      burst <= burst_next;
    end
  end

`ifndef SYNTHESIS
  // A real key only ever comes as the final result of a byte.
  a_key_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] != tked_pkg::KEY_NONE) |-> m_tlast)
    else $error("key result not marked last");

  // A completed sequence reports a real key and ends the run.
  a_seq_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[5:3] != tked_pkg::USED_ONE) |->
      m_tlast && (m_tdata[2:0] != tked_pkg::KEY_NONE))
    else $error("sequence result malformed");

  // A byte is taken over a busy output only as its final result leaves.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_accept && m_tvalid |-> m_tready && m_tlast)
    else $error("byte accepted while burst pending");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");
`endif

endmodule

>>> rtl/tked_decode.sv
// Prefix tracker and byte decoder: holds a partial escape sequence and forms the result burst.
module tked_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  output tked_pkg::burst_t burst
);

  // Bytes held: 0 nothing, 1 ESC, 2 ESC [, 3 ESC [ digit.
  logic [1:0]       held_count, held_count_next;
  // Key that the held digit stands for once the closing tilde arrives.
  tked_pkg::key_t   held_key, held_key_next;

  // Decode the new byte against what is held.
  always_comb begin
    logic fail;
    fail            = 1'b0;
    held_count_next = held_count;
    held_key_next   = held_key;
    burst           = '0;
    burst.fin_key   = tked_pkg::KEY_NONE;

    case (held_count)
      2'd0: begin
        fail = 1'b1;
      end
      2'd1: begin
        if (data_byte == tked_pkg::BYTE_LBRACK) begin
          held_count_next = 2'd2;
        end else begin
          fail = 1'b1;
        end
      end
      2'd2: begin
        case (data_byte) inside
          "A", "B", "H", "F": begin
            burst.fin_valid = 1'b1;
            burst.fin_used  = tked_pkg::USED_SHORT;
            held_count_next = 2'd0;
            case (data_byte)
              "A":     burst.fin_key = tked_pkg::KEY_UP;
              "B":     burst.fin_key = tked_pkg::KEY_DOWN;
              "H":     burst.fin_key = tked_pkg::KEY_HOME;
              default: burst.fin_key = tked_pkg::KEY_END;
            endcase
          end
          "1", "4", "5", "6": begin
            held_count_next = 2'd3;
            case (data_byte)
              "1":     held_key_next = tked_pkg::KEY_HOME;
              "4":     held_key_next = tked_pkg::KEY_END;
              "5":     held_key_next = tked_pkg::KEY_PGUP;
              default: held_key_next = tked_pkg::KEY_PGDN;
            endcase
          end
          default: begin
            fail = 1'b1;
          end
        endcase
      end
      default: begin
        if (data_byte == tked_pkg::BYTE_TILDE) begin
          burst.fin_valid = 1'b1;
          burst.fin_key   = held_key;
          burst.fin_used  = tked_pkg::USED_NUM;
          held_count_next = 2'd0;
        end else begin
          fail = 1'b1;
        end
      end
    endcase

    // A failed or empty prefix gives one none per held byte, then the byte
    // is decoded afresh; a fresh ESC opens a new prefix.
    if (fail) begin
      burst.nones = held_count;
      if (data_byte == tked_pkg::BYTE_ESC) begin
        held_count_next = 2'd1;
      end else begin
        held_count_next = 2'd0;
        burst.fin_valid = 1'b1;
        burst.fin_key   = tked_pkg::single_key(data_byte);
        burst.fin_used  = tked_pkg::USED_ONE;
      end
    end
  end

  // Prefix state register, updated on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      held_key   <= tked_pkg::KEY_NONE;
    end else if (accept) begin
      held_count <= held_count_next;
      held_key   <= held_key_next;
    end
  end

endmodule
